// File: design/keyboard_flag_stack_assert.svh
// ----------------------------------------------------------------------------
// Keyboard flag stack assertion macros
// Short forms for the concurrent checks used in the flag stack RTL.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_FLAG_STACK_ASSERT_SVH
`define KEYBOARD_FLAG_STACK_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define KFS_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define KFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define KFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/kfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard flag stack package
// Field widths, command and set-operation codes, and width helpers.
// ----------------------------------------------------------------------------
package kfs_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;

   localparam int MODE_W   = 3;
   localparam int PCOUNT_W = 2;
   localparam int VALUE_W  = 16;
   localparam int FLAGS_W  = 8;

   localparam logic [MODE_W-1:0] MODE_QUERY = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SET   = 3'd3;

   localparam logic [VALUE_W-1:0] SET_OP_REPLACE = 16'd1;
   localparam logic [VALUE_W-1:0] SET_OP_UNION   = 16'd2;
   localparam logic [VALUE_W-1:0] SET_OP_CLEAR   = 16'd3;

   // Bits needed to address a stack slot.
   function automatic int ptr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Bits needed to hold a fill count from zero up to the depth itself.
   function automatic int fill_width(input int depth);
      return $clog2(depth + 1);
   endfunction

endpackage

// File: design/kfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard flag stack channel interfaces
// Command channel and reply channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kfs_req_if;
   import kfs_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]   mode;
   logic [PCOUNT_W-1:0] param_count;
   logic [VALUE_W-1:0]  first_value;
   logic [VALUE_W-1:0]  second_value;

   modport source (output valid, output mode, output param_count,
                   output first_value, output second_value, input ready);
   modport sink   (input valid, input mode, input param_count,
                   input first_value, input second_value, output ready);
endinterface

interface kfs_rsp_if;
   import kfs_pkg::*;

   logic               valid;
   logic               ready;
   logic [FLAGS_W-1:0]  reply_flags;

   modport source (output valid, output reply_flags, input ready);
   modport sink   (input valid, input reply_flags, output ready);
endinterface

// File: design/kfs_wrap_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard flag stack wrapping adder
// Shared adder that forms a ring-buffer slot: (base + offset) mod depth.
// ----------------------------------------------------------------------------
module kfs_wrap_add #(
   parameter int DEPTH = kfs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic [kfs_pkg::ptr_width(DEPTH)-1:0]  base,
   input  logic [kfs_pkg::fill_width(DEPTH)-1:0] offset,
   output logic [kfs_pkg::ptr_width(DEPTH)-1:0]  sum
);
   import kfs_pkg::*;

   localparam int PTR_W  = ptr_width(DEPTH);
   localparam int FILL_W = fill_width(DEPTH);
   localparam int SUM_W  = FILL_W + 1;
   localparam logic [SUM_W-1:0] LIMIT = SUM_W'(DEPTH);

   logic [SUM_W-1:0] raw;
   logic [SUM_W-1:0] wrapped;

   // Base is below the depth and offset at most the depth, so a single
   // subtract brings the sum back into range.
   assign raw     = SUM_W'(base) + SUM_W'(offset);
   assign wrapped = (raw >= LIMIT) ? (raw - LIMIT) : raw;
   assign sum     = wrapped[PTR_W-1:0];

endmodule

// File: design/kfs_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard flag stack storage
// Single-port memory of saved flag values with a registered read.
// ----------------------------------------------------------------------------
module kfs_stack_mem #(
   parameter int DEPTH = kfs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic                                  rd_en,
   input  logic [kfs_pkg::ptr_width(DEPTH)-1:0]  addr,
   input  logic [kfs_pkg::FLAGS_W-1:0]           wr_data,
   output logic [kfs_pkg::FLAGS_W-1:0]           rd_data
);
   import kfs_pkg::*;

   logic [FLAGS_W-1:0] mem [DEPTH];
   logic [FLAGS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/keyboard_flag_stack.sv
`timescale 1ns / 1ps
`include "keyboard_flag_stack_assert.svh"
// ----------------------------------------------------------------------------
// Keyboard flag stack
// Keyboard-flags register with a bounded ring-buffer stack of earlier values.
// ----------------------------------------------------------------------------
//   Channel  Direction  Carries
//   req      in         mode, param_count, first_value, second_value
//   rsp      out        reply_flags (one item per query command)
//
// An item is accepted in the idle state and then runs through a small
// sequencer: set and ignored commands end in the execute step, a query
// waits there until the reply register is free, a push adds the write
// step and a pop the read and load steps, or none when it runs past the
// bottom of the stack. The steps follow from the single wrapping slot
// adder and the single-port stack memory with its registered read. Reset
// is synchronous and clears flags, fill count, ring head, the sequencer
// and the reply valid; the stack memory itself is never cleared. A stalled
// reply holds in its register while the next command is taken.
// ----------------------------------------------------------------------------
module keyboard_flag_stack #(
   parameter int STACK_DEPTH = kfs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   kfs_req_if.sink   req,
   kfs_rsp_if.source rsp
);
   import kfs_pkg::*;

   localparam int PTR_W  = ptr_width(STACK_DEPTH);
   localparam int FILL_W = fill_width(STACK_DEPTH);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(STACK_DEPTH);
   localparam logic [PTR_W:0]    HEAD_LIMIT = (PTR_W + 1)'(STACK_DEPTH);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_WRITE = 5'b00100,
      ST_READ  = 5'b01000,
      ST_LOAD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Captured command.
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [PCOUNT_W-1:0] pcount_ff, pcount_in;
   logic [VALUE_W-1:0]  first_ff, first_in;
   logic [VALUE_W-1:0]  second_ff, second_in;

   // Architectural state. The stack is a ring: head_ff is the oldest slot
   // and fill_ff the number of saved entries, so dropping the oldest entry
   // on a full push is just a head advance.
   logic [FLAGS_W-1:0] flags_ff, flags_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [PTR_W-1:0]   head_ff, head_in;

   // Reply register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FLAGS_W-1:0] rsp_flags_ff, rsp_flags_in;

   logic               accept;
   logic [FLAGS_W-1:0] arg;
   logic [VALUE_W-1:0] pop_count;
   logic               pop_fits;
   logic [VALUE_W-1:0] set_op;
   logic [FILL_W-1:0]  slot_offset;
   logic [PTR_W-1:0]   slot;
   logic [FLAGS_W-1:0] mem_rd_data;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   // A missing first parameter reads as zero flags.
   assign arg       = (pcount_ff != '0) ? first_ff[FLAGS_W-1:0] : '0;
   // A pop always removes at least one entry.
   assign pop_count = ((pcount_ff != '0) && (first_ff > VALUE_W'(1))) ? first_ff
                                                                    : VALUE_W'(1);
   assign pop_fits  = (pop_count <= VALUE_W'(fill_ff));
   // Without a second parameter the set operation is a plain replace.
   assign set_op    = pcount_ff[1] ? second_ff : SET_OP_REPLACE;

   // The shared adder advances the head in the execute step and forms the
   // top-of-stack slot (head plus fill) in the write and read steps.
   assign slot_offset = (state_ff == ST_EXEC) ? FILL_W'(1) : fill_ff;

   kfs_wrap_add #(
      .DEPTH (STACK_DEPTH)
   ) u_wrap_add (
      .base   (head_ff),
      .offset (slot_offset),
      .sum    (slot)
   );

   kfs_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .rd_en   (state_ff == ST_READ),
      .addr    (slot),
      .wr_data (flags_ff),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pcount_in    = pcount_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      flags_in     = flags_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_flags_in = rsp_flags_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req.mode;
               pcount_in = req.param_count;
               first_in  = req.first_value;
               second_in = req.second_value;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (mode_ff)
               MODE_QUERY: begin
                  // Wait here until the reply register is free.
                  if (!rsp_valid_ff || rsp.ready) begin
                     rsp_valid_in = 1'b1;
                     rsp_flags_in = flags_ff;
                     state_in     = ST_IDLE;
                  end
               end
               MODE_PUSH: begin
                  // A full stack gives up its oldest entry.
                  if (fill_ff == FILL_FULL) begin
                     head_in = slot;
                     fill_in = FILL_FULL - FILL_W'(1);
                  end
                  state_in = ST_WRITE;
               end
               MODE_POP: begin
                  if (pop_fits) begin
                     fill_in  = fill_ff - pop_count[FILL_W-1:0];
                     state_in = ST_READ;
                  end else begin
                     // Popping past the bottom empties the stack and
                     // clears the flags.
                     fill_in  = '0;
                     flags_in = '0;
                     state_in = ST_IDLE;
                  end
               end
               MODE_SET: begin
                  case (set_op)
                     SET_OP_UNION: flags_in = flags_ff | arg;
                     SET_OP_CLEAR: flags_in = flags_ff & ~arg;
                     default:      flags_in = arg;
                  endcase
                  state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_WRITE: begin
            fill_in  = fill_ff + FILL_W'(1);
            flags_in = arg;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            flags_in = mem_rd_data;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pcount_ff    <= pcount_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.reply_flags = rsp_flags_ff;

   `KFS_ASSERT_HOLDS(a_fill_in_range, clock, reset, fill_ff <= FILL_FULL, "fill exceeds depth")
   `KFS_ASSERT_HOLDS(a_head_in_range, clock, reset, {1'b0, head_ff} < HEAD_LIMIT, "head outside ring")
   `KFS_ASSERT_NEXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC, "accepted item not executed")
   `KFS_ASSERT_NEXT(a_write_grows, clock, reset, state_ff == ST_WRITE, fill_ff == $past(fill_ff) + FILL_W'(1), "push did not grow stack")

endmodule
